// ----- sv/cbq_pkg.sv -----
`default_nettype none

package cbq_pkg;

  localparam int unsigned CAPACITY_DEF    = 1024;
  localparam int unsigned CHUNK_BYTES_DEF = 8;
  localparam int unsigned POOL_W          = 11;
  localparam int unsigned LEN_W           = 4;
  localparam int unsigned DATA_W          = 64;

  typedef enum logic [1:0] {
    OP_INSERT   = 2'd0,
    OP_RETRIEVE = 2'd1,
    OP_PEEK     = 2'd2,
    OP_CLEAR    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK             = 2'd0,
    ST_BAD_LENGTH     = 2'd1,
    ST_NOT_CONFIGURED = 2'd2
  } status_t;

  typedef logic [POOL_W-1:0] count_t;

endpackage

`default_nettype wire

// ----- sv/cbq_if.sv -----
`default_nettype none

interface cbq_in_if;
  logic                         valid;
  logic                         ready;
  cbq_pkg::op_t                 opcode;
  logic [cbq_pkg::LEN_W-1:0]    length;
  logic [cbq_pkg::DATA_W-1:0]   data_word;

  modport source (output valid, output opcode, output length, output data_word, input ready);
  modport sink   (input valid, input opcode, input length, input data_word, output ready);
endinterface

interface cbq_out_if;
  logic                         valid;
  logic                         ready;
  cbq_pkg::status_t             status;
  logic [cbq_pkg::DATA_W-1:0]   read_data;
  cbq_pkg::count_t              occupied;
  cbq_pkg::count_t              free_space;

  modport source (output valid, output status, output read_data, output occupied,
                  output free_space, input ready);
  modport sink   (input valid, input status, input read_data, input occupied,
                  input free_space, output ready);
endinterface

interface cbq_cfg_if;
  logic                         valid;
  logic                         ready;
  cbq_pkg::count_t              pool_size;

  modport source (output valid, output pool_size, input ready);
  modport sink   (input valid, input pool_size, output ready);
endinterface

`default_nettype wire

// ----- sv/cbq_ram.sv -----
`default_nettype none

module cbq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                  clk,
  input  wire logic                  wr_en,
  input  wire logic [AW-1:0]         wr_addr,
  input  wire logic [WIDTH-1:0]      wr_data,
  input  wire logic                  rd_en,
  input  wire logic [AW-1:0]         rd_addr,
  output logic      [WIDTH-1:0]      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- sv/circular_byte_queue.sv -----
// Byte ring buffer. Each input word inserts, retrieves or peeks at a chunk of 1 to
// CHUNK_BYTES bytes (first byte in bits 7..0), or clears the whole queue, and yields
// exactly one result word via a stage-1 register and an output register; one word is
// accepted every cycle, limited only by the result side taking its words. The store is
// CHUNK_BYTES byte-wide banks of ceil(CAPACITY/CHUNK_BYTES) rows, each bank a RAM
// with one write and one registered read per cycle, so any chunk at any offset is
// read or written in a single pass. Writing pool_size (clamped to CAPACITY) empties
// the queue; zero leaves it unconfigured. Configure only while no word is in flight.
`default_nettype none

module circular_byte_queue #(
  parameter int unsigned CAPACITY    = cbq_pkg::CAPACITY_DEF,
  parameter int unsigned CHUNK_BYTES = cbq_pkg::CHUNK_BYTES_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  cbq_cfg_if.sink    cfg_ch,
  cbq_in_if.sink     in_ch,
  cbq_out_if.source  out_ch
);

  localparam int unsigned ROWS     = (CAPACITY + CHUNK_BYTES - 1) / CHUNK_BYTES;
  localparam int unsigned ROW_W    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned BANK_W   = (CHUNK_BYTES > 1) ? $clog2(CHUNK_BYTES) : 1;
  localparam int unsigned SUM_W    = cbq_pkg::LEN_W + 1;
  localparam int unsigned RW       = 8 * CHUNK_BYTES;
  localparam int unsigned POOL_MAX = (1 << cbq_pkg::POOL_W) - 1;
  localparam int unsigned SIZE_CAP = (CAPACITY > POOL_MAX) ? POOL_MAX : CAPACITY;

  localparam logic [ROW_W-1:0]          ROW_LAST = ROW_W'(ROWS - 1);
  localparam logic [SUM_W-1:0]          CHUNK_S  = SUM_W'(CHUNK_BYTES);
  localparam logic [cbq_pkg::LEN_W-1:0] CHUNK_L  = cbq_pkg::LEN_W'(CHUNK_BYTES);
  localparam cbq_pkg::count_t           SIZE_MAX = cbq_pkg::POOL_W'(SIZE_CAP);

  function automatic logic [ROW_W-1:0] row_inc(input logic [ROW_W-1:0] r);
    row_inc = (r == ROW_LAST) ? '0 : r + 1'b1;
  endfunction

  cbq_pkg::count_t          pool_r, fill_r, fill_nxt;
  logic [ROW_W-1:0]         wr_row_r, rd_row_r, wr_row_nxt, rd_row_nxt;
  logic [BANK_W-1:0]        wr_bank_r, rd_bank_r, wr_bank_nxt, rd_bank_nxt;

  logic                     s1_valid_r;
  cbq_pkg::status_t         s1_status_r;
  cbq_pkg::count_t          s1_occ_r, s1_free_r;
  logic [BANK_W-1:0]        s1_bank_r;
  logic [cbq_pkg::LEN_W-1:0] s1_len_r;

  logic                     out_valid_r;
  cbq_pkg::status_t         out_status_r;
  logic [cbq_pkg::DATA_W-1:0] out_data_r;
  cbq_pkg::count_t          out_occ_r, out_free_r;

  cbq_pkg::count_t          size;
  cbq_pkg::count_t          len_w;
  cbq_pkg::status_t         status_nxt;
  logic [cbq_pkg::LEN_W-1:0] rlen_nxt;
  cbq_pkg::count_t          free_nxt;
  logic                     insert_ok;
  logic                     len_bad;
  logic                     s1_adv, in_ready, in_fire, cfg_fire;
  logic [SUM_W-1:0]         wsum, rsum;

  logic [RW-1:0]            q_flat;
  logic [RW-1:0]            rot;
  logic [cbq_pkg::DATA_W-1:0] rot_ext, rdata_nxt;

  assign s1_adv   = !out_valid_r || out_ch.ready;
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_fire  = in_ch.valid && in_ready;
  assign cfg_fire = cfg_ch.valid;

  assign in_ch.ready  = in_ready;
  assign cfg_ch.ready = 1'b1;

  assign size  = (pool_r > SIZE_MAX) ? SIZE_MAX : pool_r;
  assign len_w = cbq_pkg::POOL_W'(in_ch.length);
  assign wsum  = SUM_W'(wr_bank_r) + SUM_W'(in_ch.length);
  assign rsum  = SUM_W'(rd_bank_r) + SUM_W'(in_ch.length);

  always_comb begin
    len_bad     = (in_ch.length == '0) || (in_ch.length > CHUNK_L);
    status_nxt  = cbq_pkg::ST_OK;
    fill_nxt    = fill_r;
    wr_row_nxt  = wr_row_r;
    wr_bank_nxt = wr_bank_r;
    rd_row_nxt  = rd_row_r;
    rd_bank_nxt = rd_bank_r;
    rlen_nxt    = '0;
    insert_ok   = 1'b0;
    if (size == '0) begin
      status_nxt = cbq_pkg::ST_NOT_CONFIGURED;
    end else if (in_ch.opcode == cbq_pkg::OP_CLEAR) begin
      fill_nxt    = '0;
      wr_row_nxt  = '0;
      wr_bank_nxt = '0;
      rd_row_nxt  = '0;
      rd_bank_nxt = '0;
    end else if (len_bad) begin
      status_nxt = cbq_pkg::ST_BAD_LENGTH;
    end else if (in_ch.opcode == cbq_pkg::OP_INSERT) begin
      if (len_w > size - fill_r) begin
        status_nxt = cbq_pkg::ST_BAD_LENGTH;
      end else begin
        insert_ok = 1'b1;
        fill_nxt  = fill_r + len_w;
        if (wsum >= CHUNK_S) begin
          wr_bank_nxt = BANK_W'(wsum - CHUNK_S);
          wr_row_nxt  = row_inc(wr_row_r);
        end else begin
          wr_bank_nxt = BANK_W'(wsum);
        end
      end
    end else begin
      if (len_w > fill_r) begin
        status_nxt = cbq_pkg::ST_BAD_LENGTH;
      end else begin
        rlen_nxt = in_ch.length;
        if (in_ch.opcode == cbq_pkg::OP_RETRIEVE) begin
          fill_nxt = fill_r - len_w;
          if (rsum >= CHUNK_S) begin
            rd_bank_nxt = BANK_W'(rsum - CHUNK_S);
            rd_row_nxt  = row_inc(rd_row_r);
          end else begin
            rd_bank_nxt = BANK_W'(rsum);
          end
        end
      end
    end
    free_nxt = (size >= fill_nxt) ? size - fill_nxt : '0;
  end

  for (genvar k = 0; k < CHUNK_BYTES; k++) begin : g_bank
    logic [SUM_W-1:0] wi;
    logic [ROW_W-1:0] wrow;
    logic [ROW_W-1:0] rrow;
    logic             we;
    logic [7:0]       wdata;

    always_comb begin
      if (SUM_W'(k) >= SUM_W'(wr_bank_r)) begin
        wi   = SUM_W'(k) - SUM_W'(wr_bank_r);
        wrow = wr_row_r;
      end else begin
        wi   = SUM_W'(k) + CHUNK_S - SUM_W'(wr_bank_r);
        wrow = row_inc(wr_row_r);
      end
      if (SUM_W'(k) >= SUM_W'(rd_bank_r)) begin
        rrow = rd_row_r;
      end else begin
        rrow = row_inc(rd_row_r);
      end
    end

    assign we    = in_fire && insert_ok && (wi < SUM_W'(in_ch.length));
    assign wdata = in_ch.data_word[8*wi +: 8];

    cbq_ram #(
      .WIDTH (8),
      .DEPTH (ROWS)
    ) u_ram (
      .clk     (clk),
      .wr_en   (we),
      .wr_addr (wrow),
      .wr_data (wdata),
      .rd_en   (in_fire),
      .rd_addr (rrow),
      .rd_data (q_flat[8*k +: 8])
    );
  end

  // rotate bank outputs so the byte at the read pointer lands in bits 7..0
  assign rot     = RW'({q_flat, q_flat} >> (8 * s1_bank_r));
  assign rot_ext = cbq_pkg::DATA_W'(rot);

  always_comb begin
    for (int i = 0; i < cbq_pkg::DATA_W / 8; i++) begin
      rdata_nxt[8*i +: 8] = (i < int'(s1_len_r)) ? rot_ext[8*i +: 8] : 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_r      <= '0;
      fill_r      <= '0;
      wr_row_r    <= '0;
      wr_bank_r   <= '0;
      rd_row_r    <= '0;
      rd_bank_r   <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_fire) begin
        pool_r    <= cfg_ch.pool_size;
        fill_r    <= '0;
        wr_row_r  <= '0;
        wr_bank_r <= '0;
        rd_row_r  <= '0;
        rd_bank_r <= '0;
      end else if (in_fire) begin
        fill_r    <= fill_nxt;
        wr_row_r  <= wr_row_nxt;
        wr_bank_r <= wr_bank_nxt;
        rd_row_r  <= rd_row_nxt;
        rd_bank_r <= rd_bank_nxt;
      end
      if (in_ready) begin
        s1_valid_r <= in_fire;
      end
      if (s1_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
    if (in_fire) begin
      s1_status_r <= status_nxt;
      s1_occ_r    <= fill_nxt;
      s1_free_r   <= free_nxt;
      s1_bank_r   <= rd_bank_r;
      s1_len_r    <= rlen_nxt;
    end
    if (s1_adv && s1_valid_r) begin
      out_status_r <= s1_status_r;
      out_data_r   <= rdata_nxt;
      out_occ_r    <= s1_occ_r;
      out_free_r   <= s1_free_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.read_data  = out_data_r;
  assign out_ch.occupied   = out_occ_r;
  assign out_ch.free_space = out_free_r;

endmodule

`default_nettype wire

// ----- sv/cbq_chk.sv -----
`default_nettype none

module cbq_chk (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire cbq_pkg::status_t           out_status,
  input wire logic [cbq_pkg::DATA_W-1:0] out_read_data,
  input wire cbq_pkg::count_t            out_occupied,
  input wire cbq_pkg::count_t            out_free_space
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_read_data) && $stable(out_occupied) && $stable(out_free_space))
    else $error("stalled result changed");

  a_fail_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != cbq_pkg::ST_OK |-> out_read_data == '0)
    else $error("failed operation returned data");

  a_unconfigured: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == cbq_pkg::ST_NOT_CONFIGURED |->
      out_free_space == '0 && out_occupied == '0)
    else $error("unconfigured queue reports space or data");

endmodule

bind circular_byte_queue cbq_chk u_cbq_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_status     (out_ch.status),
  .out_read_data  (out_ch.read_data),
  .out_occupied   (out_ch.occupied),
  .out_free_space (out_ch.free_space)
);

`default_nettype wire
